// ===== design/mbf_pkg.sv =====
// Package for the metaball field evaluator.
// Holds field widths, function and register codes, datapath command types.
// No dependencies.
package mbf_pkg;

	// Default store depths.
	localparam int MAX_BALLS_DEF    = 64;
	localparam int MAX_CAPSULES_DEF = 32;

	// Port field widths.
	localparam int FUNC_W     = 2;
	localparam int SLOT_W     = 6;
	localparam int COORD_W    = 16;
	localparam int STR_W      = 16;
	localparam int FIELD_W    = 32;
	localparam int BCNT_W     = 7;
	localparam int CCNT_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Internal arithmetic widths.
	localparam int DIFF_W     = 17;  // difference of two coordinates
	localparam int VEC_W      = 19;  // offset vector fed to the squarer
	localparam int MUL_B_W    = 34;  // second multiplier operand
	localparam int PROD_W     = 53;  // multiplier product
	localparam int DOT_W      = 37;  // dot product of two differences
	localparam int L2_W       = 32;  // squared segment length
	localparam int DSQ_W      = 38;  // squared distance
	localparam int NUM_W      = 50;  // divider numerator and quotient
	localparam int FRAC_SHIFT = 24;  // Q8.8 energy over Q16.16 distance to Q16.16

	// Function codes of an input word.
	localparam logic [FUNC_W-1:0] FUNC_BALL = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CAP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_EVAL = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BALL_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPSULE_COUNT = 2'd1;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_WR_BALL,
		OP_WR_CAP,
		OP_START,
		OP_RD_BALL,
		OP_RD_CAP,
		OP_LD_BALL,
		OP_LD_CAP,
		OP_DOT,
		OP_L2,
		OP_SEL,
		OP_MULI,
		OP_DIV_AXIS,
		OP_AXIS,
		OP_SQ,
		OP_DIV_TERM,
		OP_ACC,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] k;   // axis selector
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic interp;    // projection falls inside the segment
	} stat_t;

endpackage

// ===== design/mbf_ifs.sv =====
// Valid/ready channel interfaces of the metaball field evaluator.
// Depends on mbf_pkg for field widths.

interface mbf_item_if import mbf_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic        [FUNC_W-1:0]  func;
	logic        [SLOT_W-1:0]  slot;
	logic signed [COORD_W-1:0] px;
	logic signed [COORD_W-1:0] py;
	logic signed [COORD_W-1:0] pz;
	logic signed [COORD_W-1:0] qx;
	logic signed [COORD_W-1:0] qy;
	logic signed [COORD_W-1:0] qz;
	logic        [STR_W-1:0]   strength;
	logic        [STR_W-1:0]   seg_length;

	modport source (output valid, func, slot, px, py, pz, qx, qy, qz, strength,
		seg_length, input ready);
	modport sink (input valid, func, slot, px, py, pz, qx, qy, qz, strength,
		seg_length, output ready);
endinterface

interface mbf_result_if import mbf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] field_value;
	logic               saturated;

	modport source (output valid, field_value, saturated, input ready);
	modport sink (input valid, field_value, saturated, output ready);
endinterface

interface mbf_cfg_if import mbf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/mbf_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mbf_pkg for operand widths.
module mbf_div import mbf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DSQ_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic             done
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DSQ_W-1:0] den_q;
	logic [DSQ_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DSQ_W:0]   trial;
	logic             fits;

	// Trial subtraction of the divisor from the shifted remainder.
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// Control: bit counter and done flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	// Operands: the numerator register fills with quotient bits as it shifts out.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? DSQ_W'(trial - {1'b0, den_q}) : trial[DSQ_W-1:0];
		end
	end

	assign quo  = num_q;
	assign done = done_q;

endmodule

// ===== design/mbf_ctrl.sv =====
// Controller of the metaball field evaluator: configuration registers,
// handshakes and the sequencer that walks balls and capsules. Uses mbf_pkg.
module mbf_ctrl import mbf_pkg::*; #(
	parameter int MAX_BALLS    = MAX_BALLS_DEF,
	parameter int MAX_CAPSULES = MAX_CAPSULES_DEF,
	parameter int BA_W         = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1,
	parameter int CA_W         = (MAX_CAPSULES > 1) ? $clog2(MAX_CAPSULES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic [FUNC_W-1:0]     item_func,
	output logic                  item_ready,
	output logic                  result_valid,
	input  logic                  result_ready,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  cfg_ready,
	input  stat_t                 stat,
	output cmd_t                  cmd,
	output logic [BA_W-1:0]       ball_addr,
	output logic [CA_W-1:0]       cap_addr
);

	localparam int BI_W = (BA_W >= BCNT_W) ? BA_W + 1 : BCNT_W;
	localparam int CI_W = (CA_W >= CCNT_W) ? CA_W + 1 : CCNT_W;

	typedef enum logic [4:0] {
		S_IDLE, S_BNEXT, S_BLD, S_SQ, S_TDIV, S_TWAIT, S_ACC,
		S_CNEXT, S_CLD, S_DOT, S_L2, S_SEL, S_IMUL, S_IDIV, S_IWAIT, S_IAX,
		S_FIN
	} state_t;

	state_t            state_q;
	logic [BCNT_W-1:0] ball_count_q;
	logic [CCNT_W-1:0] capsule_count_q;
	logic [BI_W-1:0]   bidx_q;
	logic [CI_W-1:0]   cidx_q;
	logic [1:0]        k_q;
	logic              out_valid_q;
	logic [BI_W-1:0]   nb;
	logic [CI_W-1:0]   nc;
	logic              accept;
	logic              fin_fire;

	// Active entry counts, clamped to the store depths.
	assign nb = (32'(ball_count_q) > MAX_BALLS) ? BI_W'(MAX_BALLS) : BI_W'(ball_count_q);
	assign nc = (32'(capsule_count_q) > MAX_CAPSULES) ?
		CI_W'(MAX_CAPSULES) : CI_W'(capsule_count_q);

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign fin_fire     = (state_q == S_FIN) && (!out_valid_q || result_ready);
	assign result_valid = out_valid_q;
	assign cfg_ready    = 1'b1;
	assign ball_addr    = bidx_q[BA_W-1:0];
	assign cap_addr     = cidx_q[CA_W-1:0];

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ball_count_q    <= '0;
			capsule_count_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BALL_COUNT:    ball_count_q    <= cfg_data[BCNT_W-1:0];
				REG_CAPSULE_COUNT: capsule_count_q <= cfg_data[CCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer state, counters and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bidx_q      <= '0;
			cidx_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result_ready && !fin_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && item_func == FUNC_EVAL) begin
						bidx_q  <= '0;
						cidx_q  <= '0;
						state_q <= S_BNEXT;
					end
				end
				S_BNEXT: state_q <= (bidx_q < nb) ? S_BLD : S_CNEXT;
				S_BLD: begin
					k_q     <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					if (k_q == 2'd2) begin
						state_q <= S_TDIV;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_TDIV: state_q <= S_TWAIT;
				S_TWAIT: begin
					if (stat.div_done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (bidx_q < nb) begin
						bidx_q  <= bidx_q + 1'b1;
						state_q <= S_BNEXT;
					end else begin
						cidx_q  <= cidx_q + 1'b1;
						state_q <= S_CNEXT;
					end
				end
				S_CNEXT: state_q <= (cidx_q < nc) ? S_CLD : S_FIN;
				S_CLD: begin
					k_q     <= '0;
					state_q <= S_DOT;
				end
				S_DOT: begin
					if (k_q == 2'd2) begin
						state_q <= S_L2;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_L2: state_q <= S_SEL;
				S_SEL: begin
					k_q     <= '0;
					state_q <= stat.interp ? S_IMUL : S_SQ;
				end
				S_IMUL: state_q <= S_IDIV;
				S_IDIV: state_q <= S_IWAIT;
				S_IWAIT: begin
					if (stat.div_done) begin
						state_q <= S_IAX;
					end
				end
				S_IAX: begin
					if (k_q == 2'd2) begin
						k_q     <= '0;
						state_q <= S_SQ;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_IMUL;
					end
				end
				S_FIN: begin
					if (fin_fire) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath command for the current state.
	always_comb begin
		cmd.op = OP_NONE;
		cmd.k  = k_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (item_func)
						FUNC_BALL: cmd.op = OP_WR_BALL;
						FUNC_CAP:  cmd.op = OP_WR_CAP;
						FUNC_EVAL: cmd.op = OP_START;
						default:   cmd.op = OP_NONE;
					endcase
				end
			end
			S_BNEXT:  cmd.op = (bidx_q < nb) ? OP_RD_BALL : OP_NONE;
			S_BLD:    cmd.op = OP_LD_BALL;
			S_SQ:     cmd.op = OP_SQ;
			S_TDIV:   cmd.op = OP_DIV_TERM;
			S_ACC:    cmd.op = OP_ACC;
			S_CNEXT:  cmd.op = (cidx_q < nc) ? OP_RD_CAP : OP_NONE;
			S_CLD:    cmd.op = OP_LD_CAP;
			S_DOT:    cmd.op = OP_DOT;
			S_L2:     cmd.op = OP_L2;
			S_SEL:    cmd.op = OP_SEL;
			S_IMUL:   cmd.op = OP_MULI;
			S_IDIV:   cmd.op = OP_DIV_AXIS;
			S_IAX:    cmd.op = OP_AXIS;
			S_FIN:    cmd.op = fin_fire ? OP_FIN : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== design/mbf_dp.sv =====
// Datapath of the metaball field evaluator: entry stores, shared multiplier,
// distance and accumulation registers. Uses mbf_pkg; divider is external.
module mbf_dp import mbf_pkg::*; #(
	parameter int MAX_BALLS    = MAX_BALLS_DEF,
	parameter int MAX_CAPSULES = MAX_CAPSULES_DEF,
	parameter int BA_W         = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1,
	parameter int CA_W         = (MAX_CAPSULES > 1) ? $clog2(MAX_CAPSULES) : 1
) (
	input  logic                      clk,
	input  cmd_t                      cmd,
	input  logic [BA_W-1:0]           ball_addr,
	input  logic [CA_W-1:0]           cap_addr,
	input  logic        [SLOT_W-1:0]  slot,
	input  logic signed [COORD_W-1:0] px,
	input  logic signed [COORD_W-1:0] py,
	input  logic signed [COORD_W-1:0] pz,
	input  logic signed [COORD_W-1:0] qx,
	input  logic signed [COORD_W-1:0] qy,
	input  logic signed [COORD_W-1:0] qz,
	input  logic        [STR_W-1:0]   strength,
	input  logic        [STR_W-1:0]   seg_length,
	output logic                      div_start,
	output logic        [NUM_W-1:0]   div_num,
	output logic        [DSQ_W-1:0]   div_den,
	input  logic        [NUM_W-1:0]   div_quo,
	input  logic                      div_done,
	output stat_t                     stat,
	output logic        [FIELD_W-1:0] field_value,
	output logic                      saturated
);

	localparam logic [FIELD_W-1:0] SAT = '1;

	// Entry stores.
	logic [4*COORD_W-1:0] ball_mem  [MAX_BALLS];
	logic [3*COORD_W-1:0] cs_mem    [MAX_CAPSULES];
	logic [3*COORD_W-1:0] ce_mem    [MAX_CAPSULES];
	logic [2*STR_W-1:0]   ci_mem    [MAX_CAPSULES];
	logic [4*COORD_W-1:0] ball_rd_q;
	logic [3*COORD_W-1:0] cs_rd_q;
	logic [3*COORD_W-1:0] ce_rd_q;
	logic [2*STR_W-1:0]   ci_rd_q;

	// Working registers.
	logic signed [COORD_W-1:0] p_q   [3];
	logic signed [DIFF_W-1:0]  d_q   [3];
	logic signed [DIFF_W-1:0]  w_q   [3];
	logic signed [DIFF_W-1:0]  v_q   [3];
	logic signed [VEC_W-1:0]   vec_q [3];
	logic        [STR_W-1:0]   len_q;
	logic        [STR_W-1:0]   energy_q;
	logic signed [DOT_W-1:0]   dot_q;
	logic        [L2_W-1:0]    l2_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic        [DSQ_W-1:0]   dsq_q;
	logic        [FIELD_W-1:0] acc_q;
	logic                      sat_q;
	logic        [FIELD_W-1:0] fv_q;
	logic                      sat_out_q;

	logic signed [VEC_W-1:0]   mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [PROD_W-1:0]  prod_abs;
	logic signed [COORD_W-1:0] in_p [3];
	logic signed [DIFF_W-1:0]  d_of_k;
	logic signed [DIFF_W-1:0]  w_of_k;
	logic signed [VEC_W-1:0]   q_mag;
	logic signed [VEC_W-1:0]   q_signed;
	logic signed [DOT_W-1:0]   l2_wide;
	logic                      dot_pos;
	logic                      interp;
	logic        [FIELD_W-1:0] term;
	logic                      term_sat;
	logic        [FIELD_W:0]   sum;

	assign in_p[0] = px;
	assign in_p[1] = py;
	assign in_p[2] = pz;
	assign d_of_k  = d_q[cmd.k];
	assign w_of_k  = w_q[cmd.k];

	// Segment test: projection strictly past the start and not past the end.
	assign l2_wide = $signed({{(DOT_W-L2_W){1'b0}}, l2_q});
	assign dot_pos = !dot_q[DOT_W-1] && (dot_q != '0);
	assign interp  = dot_pos && !(dot_q > l2_wide) && (l2_q != '0);
	assign stat.interp   = interp;
	assign stat.div_done = div_done;

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ: begin
				mul_a = vec_q[cmd.k];
				mul_b = {{(MUL_B_W-VEC_W){vec_q[cmd.k][VEC_W-1]}}, vec_q[cmd.k]};
			end
			OP_DOT: begin
				mul_a = {{(VEC_W-DIFF_W){d_of_k[DIFF_W-1]}}, d_of_k};
				mul_b = {{(MUL_B_W-DIFF_W){w_of_k[DIFF_W-1]}}, w_of_k};
			end
			OP_L2: begin
				mul_a = {{(VEC_W-STR_W){1'b0}}, len_q};
				mul_b = {{(MUL_B_W-STR_W){1'b0}}, len_q};
			end
			OP_MULI: begin
				mul_a = {{(VEC_W-DIFF_W){d_of_k[DIFF_W-1]}}, d_of_k};
				mul_b = dot_q[MUL_B_W-1:0];
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Divider operands: axis projection or field term.
	assign prod_abs  = prod_q[PROD_W-1] ? -prod_q : prod_q;
	assign div_start = (cmd.op == OP_DIV_AXIS) || (cmd.op == OP_DIV_TERM);
	assign div_num   = (cmd.op == OP_DIV_AXIS) ? prod_abs[NUM_W-1:0] :
		{{(NUM_W-STR_W-FRAC_SHIFT){1'b0}}, energy_q, {FRAC_SHIFT{1'b0}}};
	assign div_den   = (cmd.op == OP_DIV_AXIS) ? {{(DSQ_W-L2_W){1'b0}}, l2_q} : dsq_q;

	// Projected axis offset, truncated toward zero.
	assign q_mag    = {1'b0, div_quo[VEC_W-2:0]};
	assign q_signed = prod_q[PROD_W-1] ? -q_mag : q_mag;

	// Term with saturation on zero distance or overflow, then clamped sum.
	always_comb begin
		if (dsq_q == '0) begin
			term     = SAT;
			term_sat = 1'b1;
		end else if (|div_quo[NUM_W-1:FIELD_W]) begin
			term     = SAT;
			term_sat = 1'b1;
		end else begin
			term     = div_quo[FIELD_W-1:0];
			term_sat = 1'b0;
		end
		sum = {1'b0, acc_q} + {1'b0, term};
	end

	// Store writes and registered reads.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_WR_BALL && 32'(slot) < MAX_BALLS) begin
			ball_mem[BA_W'(slot)] <= {strength, pz, py, px};
		end
		if (cmd.op == OP_WR_CAP && 32'(slot) < MAX_CAPSULES) begin
			cs_mem[CA_W'(slot)] <= {pz, py, px};
			ce_mem[CA_W'(slot)] <= {qz, qy, qx};
			ci_mem[CA_W'(slot)] <= {strength, seg_length};
		end
		if (cmd.op == OP_RD_BALL) begin
			ball_rd_q <= ball_mem[ball_addr];
		end
		if (cmd.op == OP_RD_CAP) begin
			cs_rd_q <= cs_mem[cap_addr];
			ce_rd_q <= ce_mem[cap_addr];
			ci_rd_q <= ci_mem[cap_addr];
		end
	end

	// Distance, projection and accumulation steps.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_START: begin
				for (int k = 0; k < 3; k++) begin
					p_q[k] <= in_p[k];
				end
				acc_q <= '0;
				sat_q <= 1'b0;
			end
			OP_LD_BALL: begin
				for (int k = 0; k < 3; k++) begin
					vec_q[k] <= VEC_W'(p_q[k]) -
						VEC_W'($signed(ball_rd_q[COORD_W*k +: COORD_W]));
				end
				energy_q <= ball_rd_q[4*COORD_W-1 -: STR_W];
			end
			OP_LD_CAP: begin
				for (int k = 0; k < 3; k++) begin
					d_q[k] <= DIFF_W'($signed(ce_rd_q[COORD_W*k +: COORD_W])) -
						DIFF_W'($signed(cs_rd_q[COORD_W*k +: COORD_W]));
					w_q[k] <= DIFF_W'(p_q[k]) -
						DIFF_W'($signed(cs_rd_q[COORD_W*k +: COORD_W]));
					v_q[k] <= DIFF_W'(p_q[k]) -
						DIFF_W'($signed(ce_rd_q[COORD_W*k +: COORD_W]));
				end
				len_q    <= ci_rd_q[STR_W-1:0];
				energy_q <= ci_rd_q[2*STR_W-1:STR_W];
			end
			OP_DOT: begin
				dot_q <= ((cmd.k == 2'd0) ? '0 : dot_q) + mul_p[DOT_W-1:0];
			end
			OP_L2: l2_q <= mul_p[L2_W-1:0];
			OP_SEL: begin
				// Before the start: distance to start; past the end: distance to end.
				if (!dot_pos) begin
					for (int k = 0; k < 3; k++) begin
						vec_q[k] <= VEC_W'(w_q[k]);
					end
				end else if (!interp) begin
					for (int k = 0; k < 3; k++) begin
						vec_q[k] <= VEC_W'(v_q[k]);
					end
				end
			end
			OP_MULI: prod_q <= mul_p;
			OP_AXIS: vec_q[cmd.k] <= q_signed - VEC_W'(w_of_k);
			OP_SQ: begin
				dsq_q <= ((cmd.k == 2'd0) ? '0 : dsq_q) + mul_p[DSQ_W-1:0];
			end
			OP_ACC: begin
				acc_q <= sum[FIELD_W] ? SAT : sum[FIELD_W-1:0];
				sat_q <= sat_q | term_sat | sum[FIELD_W];
			end
			OP_FIN: begin
				fv_q      <= acc_q;
				sat_out_q <= sat_q;
			end
			default: ;
		endcase
	end

	assign field_value = fv_q;
	assign saturated   = sat_out_q;

endmodule

// ===== design/metaball_field_evaluator.sv =====
// Top level of the metaball field evaluator.
// Depends on mbf_pkg, mbf_ifs, mbf_ctrl, mbf_dp and mbf_div.
//
//   Channel  Dir  Word contents
//   item     in   func, slot, px/py/pz, qx/qy/qz, strength, seg_length
//   result   out  field_value, saturated
//   cfg      in   index (0 ball_count, 1 capsule_count), data
//
// A query walks the balls and then the capsules; a capsule whose projection
// lands inside the segment adds a divide per axis. Each division waits on the
// bit-serial divider, which dominates. Reset clears counts and handshake
// state; stores hold garbage until written. A finished result waits in the
// output register; a further query can run but holds at its end while it waits.
module metaball_field_evaluator import mbf_pkg::*; #(
	parameter int MAX_BALLS    = MAX_BALLS_DEF,
	parameter int MAX_CAPSULES = MAX_CAPSULES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	mbf_item_if.sink       item,
	mbf_result_if.source   result,
	mbf_cfg_if.sink        cfg
);

	localparam int BA_W = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
	localparam int CA_W = (MAX_CAPSULES > 1) ? $clog2(MAX_CAPSULES) : 1;

	cmd_t               cmd;
	stat_t              stat;
	logic [BA_W-1:0]    ball_addr;
	logic [CA_W-1:0]    cap_addr;
	logic               div_start;
	logic [NUM_W-1:0]   div_num;
	logic [DSQ_W-1:0]   div_den;
	logic [NUM_W-1:0]   div_quo;
	logic               div_done;
	logic               item_ready;
	logic               result_valid;
	logic               cfg_ready;
	logic [FIELD_W-1:0] field_value;
	logic               saturated;

	// Handshake and payload hookup to the channel interfaces.
	assign item.ready         = item_ready;
	assign result.valid       = result_valid;
	assign result.field_value = field_value;
	assign result.saturated   = saturated;
	assign cfg.ready          = cfg_ready;

	mbf_ctrl #(
		.MAX_BALLS(MAX_BALLS), .MAX_CAPSULES(MAX_CAPSULES), .BA_W(BA_W), .CA_W(CA_W)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item.valid), .item_func(item.func), .item_ready(item_ready),
		.result_valid(result_valid), .result_ready(result.ready),
		.cfg_valid(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.cfg_ready(cfg_ready),
		.stat(stat), .cmd(cmd), .ball_addr(ball_addr), .cap_addr(cap_addr)
	);

	mbf_dp #(
		.MAX_BALLS(MAX_BALLS), .MAX_CAPSULES(MAX_CAPSULES), .BA_W(BA_W), .CA_W(CA_W)
	) u_dp (
		.clk(clk), .cmd(cmd), .ball_addr(ball_addr), .cap_addr(cap_addr),
		.slot(item.slot), .px(item.px), .py(item.py), .pz(item.pz),
		.qx(item.qx), .qy(item.qy), .qz(item.qz),
		.strength(item.strength), .seg_length(item.seg_length),
		.div_start(div_start), .div_num(div_num), .div_den(div_den),
		.div_quo(div_quo), .div_done(div_done), .stat(stat),
		.field_value(field_value), .saturated(saturated)
	);

	mbf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .quo(div_quo), .done(div_done)
	);

endmodule
